@@ hw/rtl/calendar_minute_up_down_counter_macros.svh @@
// Assertion helpers for the calendar counter
`ifndef CALENDAR_MINUTE_UP_DOWN_COUNTER_MACROS_SVH
`define CALENDAR_MINUTE_UP_DOWN_COUNTER_MACROS_SVH

// same-cycle implication
`define CMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/cmc_pkg.sv @@
package cmc_pkg;

  localparam logic [1:0] FUNC_ADD  = 2'd0;
  localparam logic [1:0] FUNC_SUB  = 2'd1;
  localparam logic [1:0] FUNC_LOAD = 2'd2;

  localparam logic [5:0]  MINUTE_MAX = 6'd59;
  localparam logic [4:0]  HOUR_MAX   = 5'd23;
  localparam logic [3:0]  MONTH_MAX  = 4'd12;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;

  // inverse of 25 modulo 2^14, and the largest quotient a multiple of 25 can give
  localparam logic [13:0] INV_25     = 14'd7209;
  localparam logic [13:0] MULT25_LIM = 14'd655;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [13:0] load_year;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;
  } cmd_t;

  typedef struct packed {
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [13:0] cur_year;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
  } res_t;

  localparam res_t RESET_COUNT = '{
    cur_day:    5'd1,
    cur_month:  4'd1,
    cur_year:   14'd2000,
    cur_hour:   5'd0,
    cur_minute: 6'd0
  };

  function automatic logic is_leap(input logic [13:0] y);
    logic [27:0] prod;
    logic        d25;
    logic        d4;
    logic        d16;
    prod = {14'd0, y} * {14'd0, INV_25};
    d25  = (prod[13:0] <= MULT25_LIM);
    d4   = (y[1:0] == 2'd0);
    d16  = (y[3:0] == 4'd0);
    return (d4 & ~d25) | (d16 & d25);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ hw/rtl/cmc_next.sv @@
module cmc_next (
  input  cmc_pkg::res_t count,
  input  cmc_pkg::cmd_t cmd,
  output cmc_pkg::res_t count_next
);
  import cmc_pkg::*;

  logic       leap;
  logic [4:0] cur_len;

  assign leap    = is_leap(count.cur_year);
  assign cur_len = month_len(count.cur_month, leap);

  always_comb begin
    count_next = count;
    case (cmd.func)
      FUNC_ADD: begin
        if (count.cur_minute < MINUTE_MAX) begin
          count_next.cur_minute = count.cur_minute + 6'd1;
        end else begin
          count_next.cur_minute = 6'd0;
          if (count.cur_hour < HOUR_MAX) begin
            count_next.cur_hour = count.cur_hour + 5'd1;
          end else begin
            count_next.cur_hour = 5'd0;
            if (count.cur_day < cur_len) begin
              count_next.cur_day = count.cur_day + 5'd1;
            end else begin
              count_next.cur_day = 5'd1;
              if (count.cur_month < MONTH_MAX) begin
                count_next.cur_month = count.cur_month + 4'd1;
              end else begin
                count_next.cur_month = 4'd1;
                count_next.cur_year  = (count.cur_year >= YEAR_MAX) ? 14'd0
                                                                    : count.cur_year + 14'd1;
              end
            end
          end
        end
      end
      FUNC_SUB: begin
        if (count.cur_minute != 6'd0) begin
          count_next.cur_minute = count.cur_minute - 6'd1;
        end else begin
          count_next.cur_minute = MINUTE_MAX;
          if (count.cur_hour != 5'd0) begin
            count_next.cur_hour = count.cur_hour - 5'd1;
          end else begin
            count_next.cur_hour = HOUR_MAX;
            if (count.cur_day > 5'd1) begin
              count_next.cur_day = count.cur_day - 5'd1;
            end else if (count.cur_month > 4'd1) begin
              count_next.cur_month = count.cur_month - 4'd1;
              count_next.cur_day   = month_len(count.cur_month - 4'd1, leap);
            end else begin
              // December is always 31 days
              count_next.cur_month = MONTH_MAX;
              count_next.cur_day   = 5'd31;
              count_next.cur_year  = (count.cur_year == 14'd0) ? YEAR_MAX
                                                               : count.cur_year - 14'd1;
            end
          end
        end
      end
      FUNC_LOAD: begin
        count_next.cur_day    = cmd.load_day;
        count_next.cur_month  = cmd.load_month;
        count_next.cur_year   = cmd.load_year;
        count_next.cur_hour   = cmd.load_hour;
        count_next.cur_minute = cmd.load_minute;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

endmodule

@@ hw/rtl/cmc_obuf.sv @@
module cmc_obuf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmc_pkg::res_t din,
  output logic          full,
  output logic          res_valid,
  input  logic          res_stall,
  output cmc_pkg::res_t res
);
  import cmc_pkg::*;

  logic [1:0] cnt;
  res_t       head;
  res_t       tail;
  logic       pop;

  assign pop       = res_valid & ~res_stall;
  assign res_valid = (cnt != 2'd0);
  assign full      = (cnt == 2'd2);
  assign res       = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cnt == 2'd2) begin
      head <= tail;
    end else if (push && (cnt == 2'd0 || (cnt == 2'd1 && pop))) begin
      head <= din;
    end
    if (push && cnt == 2'd1 && !pop) begin
      tail <= din;
    end
  end

endmodule

@@ hw/rtl/calendar_minute_up_down_counter.sv @@
// Results are registered in the output buffer and leave on res in order.
// Throughput: one word per cycle while cmd_stall is low; the next-date logic and
// the two-word output buffer let a new word in while a result waits.
// cmd_stall rises only when both output buffer slots hold unread words.
// Reset (rst, synchronous): count returns to 01.01.2000 00:00, buffer empties.
module calendar_minute_up_down_counter (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  cmc_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output cmc_pkg::res_t res
);
  import cmc_pkg::*;

  res_t count;
  res_t count_next;
  logic cmd_take;

  assign cmd_take = cmd_valid & ~cmd_stall;

  cmc_next u_next (
    .count      (count),
    .cmd        (cmd),
    .count_next (count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= RESET_COUNT;
    end else if (cmd_take) begin
      count <= count_next;
    end
  end

  cmc_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_take),
    .din       (count_next),
    .full      (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

@@ hw/rtl/cmc_checker.sv @@
`include "calendar_minute_up_down_counter_macros.svh"

module cmc_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_stall,
  input cmc_pkg::cmd_t cmd,
  input logic          res_valid,
  input logic          res_stall,
  input cmc_pkg::res_t res
);
  import cmc_pkg::*;

  `CMC_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "res word changed while stalled")

  `CMC_ASSERT_NOW(a_stall_full, cmd_stall, res_valid, "cmd stalled with no result pending")

  `CMC_ASSERT_NOW(a_reset_empty, $past(rst), !res_valid && !cmd_stall, "buffer not empty after reset")

  `CMC_ASSERT_NEXT(a_load_shown, cmd_valid && !cmd_stall && cmd.func == FUNC_LOAD && !res_valid, res_valid && res.cur_day == $past(cmd.load_day) && res.cur_month == $past(cmd.load_month) && res.cur_year == $past(cmd.load_year) && res.cur_hour == $past(cmd.load_hour) && res.cur_minute == $past(cmd.load_minute), "loaded date not shown")

endmodule

bind calendar_minute_up_down_counter cmc_checker u_cmc_checker (.*);

@@ dv/tb_calendar_minute_up_down_counter.sv @@
`timescale 1ns / 1ps

module tb_calendar_minute_up_down_counter;
  import cmc_pkg::*;

  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam int unsigned RANDOM_WORDS = 2000;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic res_valid;
  logic res_stall;
  res_t res;

  res_t model_count;
  res_t expected_counts[$];
  res_t due_count;
  int unsigned words_sent;
  int unsigned mismatches;
  int unsigned cycle_count;
  logic steady;

  calendar_minute_up_down_counter u_dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in(input int unsigned mo, input int unsigned y);
    if (mo == 2) begin
      return leap_year(y) ? 29 : 28;
    end
    if (mo == 4 || mo == 6 || mo == 9 || mo == 11) begin
      return 30;
    end
    return 31;
  endfunction

  function automatic res_t next_count(input res_t s, input cmd_t w);
    int unsigned mi;
    int unsigned h;
    int unsigned d;
    int unsigned mo;
    int unsigned y;
    res_t r;
    mi = s.cur_minute;
    h = s.cur_hour;
    d = s.cur_day;
    mo = s.cur_month;
    y = s.cur_year;
    case (w.func)
      FUNC_ADD: begin
        if (mi < MINUTE_MAX) begin
          mi++;
        end else begin
          mi = 0;
          if (h < HOUR_MAX) begin
            h++;
          end else begin
            h = 0;
            if (d < days_in(mo, y)) begin
              d++;
            end else begin
              d = 1;
              if (mo < MONTH_MAX) begin
                mo++;
              end else begin
                mo = 1;
                y = (y >= YEAR_MAX) ? 0 : y + 1;
              end
            end
          end
        end
      end
      FUNC_SUB: begin
        if (mi != 0) begin
          mi--;
        end else begin
          mi = MINUTE_MAX;
          if (h != 0) begin
            h--;
          end else begin
            h = HOUR_MAX;
            if (d > 1) begin
              d--;
            end else begin
              if (mo > 1) begin
                mo--;
              end else begin
                mo = MONTH_MAX;
                y = (y == 0) ? YEAR_MAX : y - 1;
              end
              d = days_in(mo, y);
            end
          end
        end
      end
      FUNC_LOAD: begin
        d = w.load_day;
        mo = w.load_month;
        y = w.load_year;
        h = w.load_hour;
        mi = w.load_minute;
      end
      default: begin
      end
    endcase
    r.cur_day = d[4:0];
    r.cur_month = mo[3:0];
    r.cur_year = y[13:0];
    r.cur_hour = h[4:0];
    r.cur_minute = mi[5:0];
    return r;
  endfunction

  function automatic cmd_t rand_word();
    logic [63:0] r;
    cmd_t w;
    r = {$urandom, $urandom};
    w = r[$bits(cmd_t)-1:0];
    return w;
  endfunction

  function automatic cmd_t op_word(input logic [1:0] f);
    cmd_t w;
    w = rand_word();
    w.func = f;
    return w;
  endfunction

  function automatic cmd_t load_word(input int unsigned d, input int unsigned mo,
                                     input int unsigned y, input int unsigned h,
                                     input int unsigned mi);
    cmd_t w;
    w = op_word(FUNC_LOAD);
    w.load_day = d[4:0];
    w.load_month = mo[3:0];
    w.load_year = y[13:0];
    w.load_hour = h[4:0];
    w.load_minute = mi[5:0];
    return w;
  endfunction

  // valid date and time, mostly placed next to a carry or borrow boundary
  function automatic cmd_t boundary_load();
    int unsigned y;
    int unsigned mo;
    int unsigned d;
    int unsigned h;
    int unsigned mi;
    int unsigned len;
    case ($urandom_range(4))
      0: y = $urandom_range(9999);
      1: y = $urandom_range(99) * 100;
      2: y = $urandom_range(2499) * 4;
      3: y = $urandom_range(1) ? YEAR_MAX : 0;
      default: y = $urandom_range(2101, 1899);
    endcase
    mo = $urandom_range(12, 1);
    len = days_in(mo, y);
    case ($urandom_range(2))
      0: d = 1;
      1: d = len;
      default: d = $urandom_range(len, 1);
    endcase
    case ($urandom_range(2))
      0: h = 0;
      1: h = HOUR_MAX;
      default: h = $urandom_range(23);
    endcase
    case ($urandom_range(2))
      0: mi = 0;
      1: mi = MINUTE_MAX;
      default: mi = $urandom_range(59);
    endcase
    return load_word(d, mo, y, h, mi);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input cmd_t w);
    while (!steady && $urandom_range(99) < 38) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= w;
    @(posedge clk);
    while (cmd_stall) begin
      @(posedge clk);
    end
    model_count = next_count(model_count, w);
    expected_counts.push_back(model_count);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_counts.size() == 0) begin
        $error("unexpected result word %p", res);
        mismatches++;
      end else begin
        due_count = expected_counts.pop_front();
        check_field("cur_day", due_count.cur_day, res.cur_day);
        check_field("cur_month", due_count.cur_month, res.cur_month);
        check_field("cur_year", due_count.cur_year, res.cur_year);
        check_field("cur_hour", due_count.cur_hour, res.cur_hour);
        check_field("cur_minute", due_count.cur_minute, res.cur_minute);
      end
    end
  end

  always @(negedge clk) begin
    res_stall <= !steady && ($urandom_range(99) < 38);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_unused_func();
    send_word(op_word(FUNC_NOP));
  endtask

  task automatic test_carry_up();
    send_word(load_word(31, 12, 9999, 23, 59));
    send_word(op_word(FUNC_ADD));
    send_word(load_word(30, 4, 2023, 23, 59));
    send_word(op_word(FUNC_ADD));
  endtask

  task automatic test_borrow_down();
    send_word(load_word(1, 1, 0, 0, 0));
    send_word(op_word(FUNC_SUB));
    send_word(load_word(1, 3, 2000, 0, 0));
    send_word(op_word(FUNC_SUB));
    send_word(load_word(1, 3, 1900, 0, 0));
    send_word(op_word(FUNC_SUB));
  endtask

  task automatic test_leap_rule();
    send_word(load_word(28, 2, 2100, 23, 59));
    send_word(op_word(FUNC_ADD));
    send_word(load_word(28, 2, 2004, 23, 59));
    send_word(op_word(FUNC_ADD));
  endtask

  // field values outside the calendar ranges, stored unchecked
  task automatic test_raw_loads();
    send_word(load_word(31, 15, 16383, 31, 63));
    send_word(op_word(FUNC_ADD));
    send_word(load_word(31, 15, 16383, 31, 63));
    send_word(op_word(FUNC_SUB));
    send_word(load_word(0, 0, 0, 0, 0));
    send_word(op_word(FUNC_SUB));
    send_word(load_word(0, 0, 0, 0, 0));
    send_word(op_word(FUNC_ADD));
  endtask

  task automatic test_random_walks();
    int unsigned base;
    int unsigned pick;
    logic [1:0] dir;
    logic [1:0] back;
    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) begin
      steady = (words_sent - base >= 800) && (words_sent - base < 1200);
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_word(boundary_load());
        dir = $urandom_range(1) ? FUNC_ADD : FUNC_SUB;
        back = (dir == FUNC_ADD) ? FUNC_SUB : FUNC_ADD;
        repeat ($urandom_range(30, 1)) begin
          send_word(op_word(($urandom_range(99) < 85) ? dir : back));
        end
      end else if (pick < 85) begin
        send_word(op_word(FUNC_LOAD));
        repeat ($urandom_range(8, 1)) begin
          send_word(op_word($urandom_range(1) ? FUNC_ADD : FUNC_SUB));
        end
      end else begin
        send_word(rand_word());
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    res_stall = 1'b0;
    steady = 1'b0;
    words_sent = 0;
    mismatches = 0;
    cycle_count = 0;
    model_count = '{cur_day: 5'd1, cur_month: 4'd1, cur_year: 14'd2000,
                    cur_hour: 5'd0, cur_minute: 6'd0};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_unused_func();
    test_carry_up();
    test_borrow_down();
    test_leap_rule();
    test_raw_loads();
    test_random_walks();
    cmd_valid <= 1'b0;
    while (expected_counts.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
